// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg
// Constants and elaboration-time helpers for the frame rotation pipeline.
// ----------------------------------------------------------------------------
package ecr_pkg;

  localparam int DEF_ANGLE_BITS    = 32;
  localparam int DEF_CORDIC_STAGES = 24;
  localparam int DEF_VECTOR_BITS   = 32;

  localparam int GUARD   = 8;   // fraction bits carried through the CORDIC
  localparam int ANG_LAT = 5;   // register stages in the angle pipeline

  localparam logic [31:0] INV_GAIN   = 32'h9B74EDA8;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;

  // rational coefficients of the sidereal angle
  localparam logic [191:0] C0_NUM  = 192'd66460656;
  localparam logic [191:0] C0_DEN  = 192'd240000000;
  localparam logic [191:0] C1_NUM  = 192'd2400051262;
  localparam logic [191:0] C1_DEN  = 192'd1753200000000;
  localparam logic [191:0] C2_NUM  = 192'd2581;
  localparam logic [191:0] C2_DEN  = 192'd1563369873046875;
  localparam logic [191:0] SID_NUM = 192'd27379093;
  localparam logic [191:0] SID_DEN = 192'd10000000000;

  // constant day term
  localparam logic [191:0] T0_FULL = (C0_NUM << 64) / C0_DEN;
  localparam logic [63:0]  T0      = T0_FULL[63:0];

  // linear term for day zero (negative century count)
  localparam logic [191:0] T1D0_FULL = ((C1_DEN - C1_NUM) << 64) / C1_DEN;
  localparam logic [63:0]  T1_DAY0   = T1D0_FULL[63:0];

  // reciprocal multipliers, rounded up; exact floor for the operand ranges used
  localparam logic [191:0] M1_FULL = ((C1_NUM << 122) + C1_DEN - 192'd1) / C1_DEN;
  localparam logic [127:0] M1      = {6'd0, M1_FULL[121:0]};
  localparam logic [191:0] M2_FULL = ((C2_NUM << 136) + C2_DEN - 192'd1) / C2_DEN;
  localparam logic [127:0] M2      = M2_FULL[127:0];
  localparam logic [191:0] M3_FULL = ((SID_NUM << 88) + SID_DEN - 192'd1) / SID_DEN;
  localparam logic [95:0]  M3      = M3_FULL[95:0];

  localparam int M1_LIMBS = 4;
  localparam int M2_LIMBS = 4;
  localparam int M3_LIMBS = 3;

  // restoring divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) as a 64-bit fraction of a turn, elaboration only
  function automatic logic [63:0] atan_turns(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] res;
    int          e;
    rad = '0;
    res = '0;
    q   = TWO_PI_Q61 >> 2;
    if (i == 0) return 64'd1 << 61;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e < 64) begin
        term = udiv64(64'd1 << (64 - e), 64'(2 * k + 1));
        if (k % 2 == 1) rad = rad - term;
        else rad = rad + term;
      end
    end
    r = rad >> 2;
    for (int n = 0; n < 61; n++) begin
      r   = r << 1;
      res = res << 1;
      if (r >= q) begin
        r      = r - q;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// File: hdl/ecr_angle.sv
// ----------------------------------------------------------------------------
// ecr_angle
// Five-stage pipeline producing the signed rotation angle from the time stamp.
// ----------------------------------------------------------------------------
module ecr_angle #(
  parameter int ANGLE_BITS = ecr_pkg::DEF_ANGLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  input  logic [15:0]           in_day_number,
  input  logic [31:0]           in_day_fraction,
  output logic                  out_valid,
  output logic [ANGLE_BITS-1:0] out_psi
);
  import ecr_pkg::*;

  logic [ANG_LAT-1:0] vld_r;

  // stage 0
  logic [16:0] ad_r, ad_nxt;
  logic        day0_s0_r, cmd_s0_r;
  logic [31:0] frac_s0_r;
  // stage 1
  logic [33:0] ad2_r, ad2_nxt;
  logic [48:0] pp1_r [M1_LIMBS];
  logic [48:0] pp1_nxt [M1_LIMBS];
  logic [63:0] pp3_r [M3_LIMBS];
  logic [63:0] pp3_nxt [M3_LIMBS];
  logic        day0_s1_r, cmd_s1_r;
  logic [31:0] frac_s1_r;
  // stage 2
  logic [63:0]  t1_r, t1_nxt, t3_r, t3_nxt;
  logic [48:0]  pp2_r [2][M2_LIMBS];
  logic [48:0]  pp2_nxt [2][M2_LIMBS];
  logic [127:0] sum1, sum3;
  logic         cmd_s2_r;
  logic [31:0]  frac_s2_r;
  // stage 3
  logic [63:0]  t1_s3_r, t3_s3_r, t2_r, t2_nxt;
  logic [167:0] sum2;
  logic         cmd_s3_r;
  logic [31:0]  frac_s3_r;
  // stage 4
  logic [63:0]           ang_sum;
  logic [ANGLE_BITS-1:0] theta;
  logic [ANGLE_BITS-1:0] psi_r, psi_nxt;

  always_comb begin
    ad_nxt = (in_day_number == 16'd0) ? 17'd1 : ({in_day_number, 1'b0} - 17'd1);
    ad2_nxt = 34'(ad_r) * 34'(ad_r);
    for (int j = 0; j < M1_LIMBS; j++) pp1_nxt[j] = 49'(ad_r) * 49'(M1[32*j +: 32]);
    for (int j = 0; j < M3_LIMBS; j++) pp3_nxt[j] = 64'(frac_s0_r) * 64'(M3[32*j +: 32]);

    sum1 = '0;
    for (int j = 0; j < M1_LIMBS; j++) sum1 = sum1 + (128'(pp1_r[j]) << (32*j));
    t1_nxt = day0_s1_r ? T1_DAY0 : sum1[121:58];
    sum3 = '0;
    for (int j = 0; j < M3_LIMBS; j++) sum3 = sum3 + (128'(pp3_r[j]) << (32*j));
    t3_nxt = sum3[119:56];
    for (int h = 0; h < 2; h++)
      for (int j = 0; j < M2_LIMBS; j++)
        pp2_nxt[h][j] = 49'(ad2_r[17*h +: 17]) * 49'(M2[32*j +: 32]);

    sum2 = '0;
    for (int h = 0; h < 2; h++)
      for (int j = 0; j < M2_LIMBS; j++)
        sum2 = sum2 + (168'(pp2_r[h][j]) << (17*h + 32*j));
    t2_nxt = sum2[148:85];

    ang_sum = T0 + t1_s3_r + t2_r + {frac_s3_r, 32'h0} + t3_s3_r;
    theta   = ang_sum[63 -: ANGLE_BITS];
    psi_nxt = cmd_s3_r ? theta : (ANGLE_BITS'(0) - theta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ANG_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ad_r      <= ad_nxt;
    day0_s0_r <= (in_day_number == 16'd0);
    cmd_s0_r  <= in_command;
    frac_s0_r <= in_day_fraction;

    ad2_r     <= ad2_nxt;
    pp1_r     <= pp1_nxt;
    pp3_r     <= pp3_nxt;
    day0_s1_r <= day0_s0_r;
    cmd_s1_r  <= cmd_s0_r;
    frac_s1_r <= frac_s0_r;

    t1_r      <= t1_nxt;
    t3_r      <= t3_nxt;
    pp2_r     <= pp2_nxt;
    cmd_s2_r  <= cmd_s1_r;
    frac_s2_r <= frac_s1_r;

    t1_s3_r   <= t1_r;
    t3_s3_r   <= t3_r;
    t2_r      <= t2_nxt;
    cmd_s3_r  <= cmd_s2_r;
    frac_s3_r <= frac_s2_r;

    psi_r     <= psi_nxt;
  end

  assign out_valid = vld_r[ANG_LAT-1];
  assign out_psi   = psi_r;

endmodule

// File: hdl/ecr_cordic.sv
// ----------------------------------------------------------------------------
// ecr_cordic
// Quadrant fold, one register per CORDIC iteration, gain removal and rounding.
// ----------------------------------------------------------------------------
module ecr_cordic #(
  parameter int ANGLE_BITS    = ecr_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = ecr_pkg::DEF_CORDIC_STAGES,
  parameter int VECTOR_BITS   = ecr_pkg::DEF_VECTOR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ANGLE_BITS-1:0]         in_psi,
  input  logic signed [VECTOR_BITS-1:0] in_x,
  input  logic signed [VECTOR_BITS-1:0] in_y,
  input  logic signed [VECTOR_BITS-1:0] in_z,
  output logic                          out_valid,
  output logic signed [VECTOR_BITS-1:0] out_x,
  output logic signed [VECTOR_BITS-1:0] out_y,
  output logic signed [VECTOR_BITS-1:0] out_z
);
  import ecr_pkg::*;

  localparam int W   = VECTOR_BITS + GUARD + 3;
  localparam int ZW  = ANGLE_BITS + 1;
  localparam int LAT = CORDIC_STAGES + 3;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic signed [65:0] SAT_HI  = (66'sd1 <<< (VECTOR_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO  = -SAT_HI - 66'sd1;
  localparam logic signed [65:0] RND     = 66'sd1 <<< (GUARD - 1);

  logic [LAT-1:0] vld_r;
  logic signed [VECTOR_BITS-1:0] zd_r [LAT];

  logic signed [W-1:0]  x_r [CORDIC_STAGES+1];
  logic signed [W-1:0]  y_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_r [CORDIC_STAGES+1];

  // fold
  logic [ANGLE_BITS-1:0] psi_q, psi_f;
  logic                  flip;
  logic signed [W-1:0]   xe, ye, x0_nxt, y0_nxt;
  logic signed [ZW-1:0]  z0_nxt;

  always_comb begin
    psi_q  = in_psi + QUARTER;
    flip   = psi_q[ANGLE_BITS-1];
    psi_f  = flip ? (in_psi ^ HALF) : in_psi;
    xe     = {{3{in_x[VECTOR_BITS-1]}}, in_x, {GUARD{1'b0}}};
    ye     = {{3{in_y[VECTOR_BITS-1]}}, in_y, {GUARD{1'b0}}};
    x0_nxt = flip ? -xe : xe;
    y0_nxt = flip ? -ye : ye;
    z0_nxt = {psi_f[ANGLE_BITS-1], psi_f};
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x0_nxt;
    y_r[0] <= y0_nxt;
    z_r[0] <= z0_nxt;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    localparam logic [63:0]    AT_FULL = atan_turns(g);
    localparam logic [ZW-1:0]  AT      = {1'b0, AT_FULL[63 -: ANGLE_BITS]};
    logic signed [W-1:0]  dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      dx = y_r[g] >>> g;
      dy = x_r[g] >>> g;
      if (z_r[g][ZW-1]) begin
        x_nxt = x_r[g] + dx;
        y_nxt = y_r[g] - dy;
        z_nxt = z_r[g] + $signed(AT);
      end else begin
        x_nxt = x_r[g] - dx;
        y_nxt = y_r[g] + dy;
        z_nxt = z_r[g] - $signed(AT);
      end
    end

    always_ff @(posedge clk) begin
      x_r[g+1] <= x_nxt;
      y_r[g+1] <= y_nxt;
      z_r[g+1] <= z_nxt;
    end
  end

  // gain removal: lane 0 is x, lane 1 is y
  logic signed [W-1:0] gv [2];
  logic [W-1:0]        mag [2];
  logic [63:0]         m64 [2];
  logic [63:0]         ph_r [2];
  logic [63:0]         ph_nxt [2];
  logic [63:0]         pl_r [2];
  logic [63:0]         pl_nxt [2];
  logic [1:0]          neg_r, neg_nxt;
  logic [65:0]         gr [2];
  logic signed [65:0]  sv [2];
  logic signed [65:0]  rv [2];
  logic signed [VECTOR_BITS-1:0] sat_nxt [2];
  logic signed [VECTOR_BITS-1:0] ox_r, oy_r;

  always_comb begin
    gv[0] = x_r[CORDIC_STAGES];
    gv[1] = y_r[CORDIC_STAGES];
    for (int l = 0; l < 2; l++) begin
      neg_nxt[l] = gv[l][W-1];
      mag[l]     = neg_nxt[l] ? W'(-gv[l]) : W'(gv[l]);
      m64[l]     = 64'(mag[l]);
      ph_nxt[l]  = 64'(m64[l][63:32]) * 64'(INV_GAIN);
      pl_nxt[l]  = 64'(m64[l][31:0]) * 64'(INV_GAIN);

      gr[l] = {2'b00, ph_r[l]} + {34'd0, pl_r[l][63:32]};
      sv[l] = neg_r[l] ? -$signed(gr[l]) : $signed(gr[l]);
      rv[l] = (sv[l] + RND) >>> GUARD;
      if (rv[l] > SAT_HI)      sat_nxt[l] = SAT_HI[VECTOR_BITS-1:0];
      else if (rv[l] < SAT_LO) sat_nxt[l] = SAT_LO[VECTOR_BITS-1:0];
      else                     sat_nxt[l] = rv[l][VECTOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ph_r  <= ph_nxt;
    pl_r  <= pl_nxt;
    neg_r <= neg_nxt;
    ox_r  <= sat_nxt[0];
    oy_r  <= sat_nxt[1];
    zd_r[0] <= in_z;
    for (int k = 1; k < LAT; k++) zd_r[k] <= zd_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = zd_r[LAT-1];

endmodule

// File: hdl/eci_ecr_frame_rotation.sv
// Throughput: one transaction per cycle; busy is held low and every start is taken.
// Latency is set by the 5-stage angle pipeline, one register per CORDIC iteration,
// the quadrant fold and two gain/round stages.
// Reset (synchronous, active low) clears only the valid pipeline; results are
// strobed for one cycle on out_valid and the receiver cannot stall.
// ----------------------------------------------------------------------------
// eci_ecr_frame_rotation
// Rotates a vector about z by the Greenwich mean sidereal angle of its time stamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eci_ecr_frame_rotation #(
  parameter int ANGLE_BITS    = ecr_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STAGES = ecr_pkg::DEF_CORDIC_STAGES,
  parameter int VECTOR_BITS   = ecr_pkg::DEF_VECTOR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [15:0]                   in_day_number,
  input  logic [31:0]                   in_day_fraction,
  input  logic signed [VECTOR_BITS-1:0] in_vec_x,
  input  logic signed [VECTOR_BITS-1:0] in_vec_y,
  input  logic signed [VECTOR_BITS-1:0] in_vec_z,
  output logic                          out_valid,
  output logic signed [VECTOR_BITS-1:0] out_x,
  output logic signed [VECTOR_BITS-1:0] out_y,
  output logic signed [VECTOR_BITS-1:0] out_z
);
  import ecr_pkg::*;

  localparam int TOTAL_LAT = ANG_LAT + CORDIC_STAGES + 3;

  logic                          accept;
  logic                          ang_valid;
  logic [ANGLE_BITS-1:0]         ang_psi;
  logic                          zero_vec_in;

  // vector delay line matching the angle pipeline
  logic signed [VECTOR_BITS-1:0] xd_r [ANG_LAT];
  logic signed [VECTOR_BITS-1:0] yd_r [ANG_LAT];
  logic signed [VECTOR_BITS-1:0] zd_r [ANG_LAT];

  // no back-pressure anywhere: the pipeline advances every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ecr_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (accept),
    .in_command     (in_command),
    .in_day_number  (in_day_number),
    .in_day_fraction(in_day_fraction),
    .out_valid      (ang_valid),
    .out_psi        (ang_psi)
  );

  always_ff @(posedge clk) begin
    xd_r[0] <= in_vec_x;
    yd_r[0] <= in_vec_y;
    zd_r[0] <= in_vec_z;
    for (int k = 1; k < ANG_LAT; k++) begin
      xd_r[k] <= xd_r[k-1];
      yd_r[k] <= yd_r[k-1];
      zd_r[k] <= zd_r[k-1];
    end
  end

  ecr_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .VECTOR_BITS  (VECTOR_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ang_valid),
    .in_psi   (ang_psi),
    .in_x     (xd_r[ANG_LAT-1]),
    .in_y     (yd_r[ANG_LAT-1]),
    .in_z     (zd_r[ANG_LAT-1]),
    .out_valid(out_valid),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z)
  );

  assign zero_vec_in = (in_vec_x == '0) && (in_vec_y == '0);

  // every strobe traces back to a transaction taken by the pipeline
  `ECR_ASSERT_IMP(a_out_has_source, out_valid, $past(accept, TOTAL_LAT), "orphan result")
  // z must ride the pipeline unchanged
  `ECR_ASSERT_IMP(a_z_pass, out_valid, out_z == $past(in_vec_z, TOTAL_LAT), "z mismatch")
  // a zero vector stays zero at any angle
  `ECR_ASSERT_IMP(a_zero_vec, out_valid && $past(zero_vec_in, TOTAL_LAT), (out_x == '0) && (out_y == '0), "zero vector rotated")

endmodule
